### sv/ffa_pkg.sv
// Package: constants, types and helpers shared by the flocking force accumulator
`timescale 1ns / 1ps
`default_nettype none
package ffa_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int MAX_NEIGHBORS = 256;
   localparam int CNT_W         = $clog2(MAX_NEIGHBORS + 1);
   localparam int VAL_W         = 32;
   localparam int RAD_W         = 31;
   localparam int SUM_W         = 48;
   localparam int DIFF_W        = VAL_W + 1;
   localparam int WIDE_W        = 66;
   localparam int AXES          = 3;
   localparam int FORCES        = 9;
   localparam int CSR_IDX_W     = 2;
   localparam int DIV_NUM_W     = 64;
   localparam int DIV_DEN_W     = 32;
   localparam int DIV_CNT_W     = $clog2(DIV_NUM_W);
   localparam int SQRT_IN_W     = 64;
   localparam int SQRT_OUT_W    = SQRT_IN_W / 2;
   localparam int SQRT_CNT_W    = $clog2(SQRT_OUT_W);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [RAD_W-1:0] SEP_RAD_RESET   = 31'd327680;
   localparam logic [RAD_W-1:0] ALI_RAD_RESET   = 31'd655360;
   localparam logic [RAD_W-1:0] COH_RAD_RESET   = 31'd655360;
   localparam logic [RAD_W-1:0] MAX_SPEED_RESET = 31'd655360;

   localparam logic [SUM_W-1:0] NORM_HI = SUM_W'(64'd1 << 30);
   localparam logic [SUM_W-1:0] NORM_LO = SUM_W'(64'd1 << 29);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEP_RAD   = 2'd0,
      CSR_ALI_RAD   = 2'd1,
      CSR_COH_RAD   = 2'd2,
      CSR_MAX_SPEED = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      GRP_SEP = 2'd0,
      GRP_ALI = 2'd1,
      GRP_COH = 2'd2
   } grp_type;

   typedef struct packed {
      logic [RAD_W-1:0] sep_rad;
      logic [RAD_W-1:0] ali_rad;
      logic [RAD_W-1:0] coh_rad;
      logic [RAD_W-1:0] max_speed;
   } cfg_type;

   typedef struct packed {
      logic                       is_neighbor;
      logic                       last;
      logic [AXES-1:0][VAL_W-1:0] pos;
      logic [AXES-1:0][VAL_W-1:0] vel;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } q_head_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
   } div_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [SQRT_IN_W-1:0] n;
   } sqrt_req_type;

   typedef struct packed {
      logic                  done;
      logic [SQRT_OUT_W-1:0] root;
   } sqrt_rsp_type;

   typedef logic [FORCES-1:0][VAL_W-1:0] result_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQ_MUL,
      ST_SQ_ACC,
      ST_DIST,
      ST_DIST_WAIT,
      ST_CLASSIFY,
      ST_U_DIV,
      ST_U_WAIT,
      ST_T_DIV,
      ST_T_WAIT,
      ST_CHECK_LAST,
      ST_GROUP,
      ST_C_DIV,
      ST_C_WAIT,
      ST_ABS,
      ST_NORM,
      ST_M_MUL,
      ST_M_ACC,
      ST_MAG,
      ST_MAG_WAIT,
      ST_S_MUL,
      ST_S_DIV,
      ST_S_WAIT,
      ST_EMIT
   } back_state_type;

   function automatic logic [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(64'sd2147483647);
      lo = -WIDE_W'(64'sd2147483648);
      if (v > hi) return 32'h7fff_ffff;
      else if (v < lo) return 32'h8000_0000;
      else return v[VAL_W-1:0];
   endfunction

endpackage
`default_nettype wire

### sv/ffa_if.sv
// Interfaces: request and response channels with valid/ready handshake
`timescale 1ns / 1ps
`default_nettype none
interface ffa_req_if import ffa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             req_type;
   logic [VAL_W-1:0] pos_x;
   logic [VAL_W-1:0] pos_y;
   logic [VAL_W-1:0] pos_z;
   logic [VAL_W-1:0] vel_x;
   logic [VAL_W-1:0] vel_y;
   logic [VAL_W-1:0] vel_z;
   logic             last;

   modport source (output valid, req_type, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, last,
                   input ready);
   modport sink (input valid, req_type, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, last,
                 output ready);
endinterface

interface ffa_rsp_if import ffa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] sep_x;
   logic [VAL_W-1:0] sep_y;
   logic [VAL_W-1:0] sep_z;
   logic [VAL_W-1:0] align_x;
   logic [VAL_W-1:0] align_y;
   logic [VAL_W-1:0] align_z;
   logic [VAL_W-1:0] coh_x;
   logic [VAL_W-1:0] coh_y;
   logic [VAL_W-1:0] coh_z;

   modport source (output valid, sep_x, sep_y, sep_z, align_x, align_y, align_z,
                   coh_x, coh_y, coh_z, input ready);
   modport sink (input valid, sep_x, sep_y, sep_z, align_x, align_y, align_z,
                 coh_x, coh_y, coh_z, output ready);
endinterface
`default_nettype wire

### sv/ffa_queue.sv
// Front end: accepts request transfers, classifies them and queues them for the back end
`timescale 1ns / 1ps
`default_nettype none
module ffa_queue import ffa_pkg::*; (
   input  wire           clock,
   input  wire           reset,
   ffa_req_if.sink       req_if,
   output q_head_type    q_head,
   input  wire           pop
);

   item_type          mem_ff [QUEUE_DEPTH];
   item_type          mem_in [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              push;
   logic              do_pop;
   item_type          new_item;

   assign req_if.ready = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign push         = req_if.valid && req_if.ready;
   assign do_pop       = pop && (cnt_ff != '0);

   always_comb begin
      new_item.is_neighbor = req_if.req_type;
      new_item.last        = req_if.last;
      new_item.pos         = {req_if.pos_z, req_if.pos_y, req_if.pos_x};
      new_item.vel         = {req_if.vel_z, req_if.vel_y, req_if.vel_x};
   end

   always_comb begin
      mem_in    = mem_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         mem_in[wr_ptr_ff] = new_item;
         wr_ptr_in         = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   assign q_head.valid = (cnt_ff != '0);
   assign q_head.item  = mem_ff[rd_ptr_ff];

endmodule
`default_nettype wire

### sv/ffa_div.sv
// Iterative unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module ffa_div import ffa_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W:0]   shifted;
   logic [DIV_DEN_W:0]   diff;
   logic                 ge;

   assign shifted = {rem_ff, num_ff[DIV_NUM_W-1]};
   assign ge      = (shifted >= {1'b0, den_ff});
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = div_req.num;
         den_in  = div_req.den;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_NUM_W-2:0], 1'b0};
         rem_in = ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule
`default_nettype wire

### sv/ffa_sqrt.sv
// Iterative integer square root, one result bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module ffa_sqrt import ffa_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   input  sqrt_req_type sqrt_req,
   output sqrt_rsp_type sqrt_rsp
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [SQRT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SQRT_IN_W-1:0]  n_ff, n_in;
   logic [SQRT_IN_W-1:0]  res_ff, res_in;
   logic [SQRT_IN_W-1:0]  bit_ff, bit_in;
   logic [SQRT_IN_W-1:0]  trial;

   assign trial = res_ff + bit_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (sqrt_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         n_in    = sqrt_req.n;
         res_in  = '0;
         bit_in  = SQRT_IN_W'(1) << (SQRT_IN_W - 2);
      end else if (busy_ff) begin
         if (n_ff >= trial) begin
            n_in   = n_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == SQRT_CNT_W'(SQRT_OUT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      n_ff   <= n_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sqrt_rsp.done = done_ff;
   assign sqrt_rsp.root = res_ff[SQRT_OUT_W-1:0];

endmodule
`default_nettype wire

### sv/ffa_back.sv
// Back end: accumulates neighbor contributions and forms the three steering forces
`timescale 1ns / 1ps
`default_nettype none
module ffa_back import ffa_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   input  cfg_type      cfg,
   input  q_head_type   q_head,
   output logic         pop,
   output div_req_type  div_req,
   input  div_rsp_type  div_rsp,
   output sqrt_req_type sqrt_req,
   input  sqrt_rsp_type sqrt_rsp,
   ffa_rsp_if.source    rsp_if
);

   back_state_type state_ff, state_in;
   item_type       item_ff, item_in;

   logic signed [VAL_W-1:0]  agent_pos_ff [AXES], agent_pos_in [AXES];
   logic signed [VAL_W-1:0]  agent_vel_ff [AXES], agent_vel_in [AXES];
   logic signed [SUM_W-1:0]  sep_sum_ff [AXES], sep_sum_in [AXES];
   logic signed [SUM_W-1:0]  vel_sum_ff [AXES], vel_sum_in [AXES];
   logic signed [SUM_W-1:0]  pos_sum_ff [AXES], pos_sum_in [AXES];
   logic [CNT_W-1:0]         sep_cnt_ff, sep_cnt_in;
   logic [CNT_W-1:0]         ali_cnt_ff, ali_cnt_in;
   logic [CNT_W-1:0]         coh_cnt_ff, coh_cnt_in;
   logic signed [DIFF_W-1:0] d_ff [AXES], d_in [AXES];
   logic signed [SUM_W-1:0]  vec_ff [AXES], vec_in [AXES];
   logic [SUM_W-1:0]         a_ff [AXES], a_in [AXES];
   logic [AXES-1:0]          neg_ff, neg_in;
   logic [1:0]               ax_ff, ax_in;
   logic [1:0]               grp_ff, grp_in;
   logic [63:0]              acc_ff, acc_in;
   logic [63:0]              prod_ff, prod_in;
   logic [63:0]              umag_ff, umag_in;
   logic [SQRT_OUT_W-1:0]    dist_ff, dist_in;
   logic [SQRT_OUT_W-1:0]    mag_ff, mag_in;
   result_type               res_ff, res_in;
   result_type               out_ff, out_in;
   logic                     out_valid_ff, out_valid_in;

   logic signed [DIFF_W-1:0] diff [AXES];
   logic                     near;
   logic [VAL_W-1:0]         d_abs;
   logic [SUM_W-1:0]         p_abs;
   logic [SUM_W-1:0]         m_val;
   logic [CNT_W-1:0]         grp_cnt;
   logic                     sep_ok, ali_ok, coh_ok;
   logic                     last_grp;
   logic                     emit_load;
   logic [3:0]               res_idx;
   logic [VAL_W-1:0]         op_a, op_b;
   logic signed [WIDE_W-1:0] q_wide;

   // offsets and the far-neighbor check
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         diff[i] = DIFF_W'(agent_pos_ff[i]) - DIFF_W'($signed(q_head.item.pos[i]));
      end
      near = 1'b1;
      for (int i = 0; i < AXES; i++) begin
         if ((diff[i][DIFF_W-1] != diff[i][DIFF_W-2]) ||
             (diff[i] == {2'b11, {(DIFF_W-2){1'b0}}})) begin
            near = 1'b0;
         end
      end
   end

   assign d_abs = d_ff[ax_ff][DIFF_W-1] ? VAL_W'(-d_ff[ax_ff]) : VAL_W'(d_ff[ax_ff]);
   assign p_abs = pos_sum_ff[ax_ff][SUM_W-1] ? SUM_W'(-pos_sum_ff[ax_ff])
                                             : SUM_W'(pos_sum_ff[ax_ff]);

   always_comb begin
      m_val = a_ff[0];
      if (a_ff[1] > m_val) m_val = a_ff[1];
      if (a_ff[2] > m_val) m_val = a_ff[2];
   end

   always_comb begin
      case (grp_ff)
         GRP_SEP: grp_cnt = sep_cnt_ff;
         GRP_ALI: grp_cnt = ali_cnt_ff;
         GRP_COH: grp_cnt = coh_cnt_ff;
         default: grp_cnt = '0;
      endcase
   end

   assign sep_ok   = (dist_ff < SQRT_OUT_W'(cfg.sep_rad)) && (sep_cnt_ff < CNT_W'(MAX_NEIGHBORS));
   assign ali_ok   = (dist_ff < SQRT_OUT_W'(cfg.ali_rad)) && (ali_cnt_ff < CNT_W'(MAX_NEIGHBORS));
   assign coh_ok   = (dist_ff < SQRT_OUT_W'(cfg.coh_rad)) && (coh_cnt_ff < CNT_W'(MAX_NEIGHBORS));
   assign last_grp = (grp_ff == GRP_COH);
   assign emit_load = !out_valid_ff || rsp_if.ready;
   assign res_idx  = 4'(grp_ff) * 4'd3 + 4'(ax_ff);
   assign q_wide   = $signed({2'b00, div_rsp.quo});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               if (q_head.item.is_neighbor && near) state_in = ST_SQ_MUL;
               else state_in = ST_CHECK_LAST;
            end
         end
         ST_SQ_MUL: state_in = ST_SQ_ACC;
         ST_SQ_ACC: state_in = (ax_ff == 2'd2) ? ST_DIST : ST_SQ_MUL;
         ST_DIST: state_in = ST_DIST_WAIT;
         ST_DIST_WAIT: if (sqrt_rsp.done) state_in = ST_CLASSIFY;
         ST_CLASSIFY: state_in = (dist_ff != '0 && sep_ok) ? ST_U_DIV : ST_CHECK_LAST;
         ST_U_DIV: state_in = ST_U_WAIT;
         ST_U_WAIT: if (div_rsp.done) state_in = ST_T_DIV;
         ST_T_DIV: state_in = ST_T_WAIT;
         ST_T_WAIT: begin
            if (div_rsp.done) state_in = (ax_ff == 2'd2) ? ST_CHECK_LAST : ST_U_DIV;
         end
         ST_CHECK_LAST: state_in = item_ff.last ? ST_GROUP : ST_IDLE;
         ST_GROUP: begin
            if (grp_cnt == '0) state_in = last_grp ? ST_EMIT : ST_GROUP;
            else state_in = last_grp ? ST_C_DIV : ST_ABS;
         end
         ST_C_DIV: state_in = ST_C_WAIT;
         ST_C_WAIT: begin
            if (div_rsp.done) state_in = (ax_ff == 2'd2) ? ST_ABS : ST_C_DIV;
         end
         ST_ABS: state_in = ST_NORM;
         ST_NORM: begin
            if (m_val == '0) state_in = last_grp ? ST_EMIT : ST_GROUP;
            else if (m_val >= NORM_HI || m_val < NORM_LO) state_in = ST_NORM;
            else state_in = ST_M_MUL;
         end
         ST_M_MUL: state_in = ST_M_ACC;
         ST_M_ACC: state_in = (ax_ff == 2'd2) ? ST_MAG : ST_M_MUL;
         ST_MAG: state_in = ST_MAG_WAIT;
         ST_MAG_WAIT: if (sqrt_rsp.done) state_in = ST_S_MUL;
         ST_S_MUL: state_in = ST_S_DIV;
         ST_S_DIV: state_in = ST_S_WAIT;
         ST_S_WAIT: begin
            if (div_rsp.done) begin
               if (ax_ff != 2'd2) state_in = ST_S_MUL;
               else state_in = last_grp ? ST_EMIT : ST_GROUP;
            end
         end
         ST_EMIT: if (emit_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs and shared-unit operands
   always_comb begin
      pop          = (state_ff == ST_IDLE) && q_head.valid;
      div_req      = '0;
      sqrt_req     = '0;
      op_a         = '0;
      op_b         = '0;
      div_req.start  = (state_ff inside {ST_U_DIV, ST_T_DIV, ST_C_DIV, ST_S_DIV});
      sqrt_req.start = (state_ff inside {ST_DIST, ST_MAG});
      sqrt_req.n     = acc_ff;
      case (state_ff)
         ST_U_DIV: begin
            div_req.num = DIV_NUM_W'(d_abs) << FRAC_BITS;
            div_req.den = dist_ff;
         end
         ST_T_DIV: begin
            div_req.num = umag_ff << FRAC_BITS;
            div_req.den = dist_ff;
         end
         ST_C_DIV: begin
            div_req.num = DIV_NUM_W'(p_abs);
            div_req.den = DIV_DEN_W'(coh_cnt_ff);
         end
         ST_S_DIV: begin
            div_req.num = prod_ff;
            div_req.den = mag_ff;
         end
         ST_SQ_MUL: begin
            op_a = d_abs;
            op_b = d_abs;
         end
         ST_M_MUL: begin
            op_a = a_ff[ax_ff][VAL_W-1:0];
            op_b = a_ff[ax_ff][VAL_W-1:0];
         end
         ST_S_MUL: begin
            op_a = a_ff[ax_ff][VAL_W-1:0];
            op_b = VAL_W'(cfg.max_speed);
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      item_in      = item_ff;
      agent_pos_in = agent_pos_ff;
      agent_vel_in = agent_vel_ff;
      sep_sum_in   = sep_sum_ff;
      vel_sum_in   = vel_sum_ff;
      pos_sum_in   = pos_sum_ff;
      sep_cnt_in   = sep_cnt_ff;
      ali_cnt_in   = ali_cnt_ff;
      coh_cnt_in   = coh_cnt_ff;
      d_in         = d_ff;
      vec_in       = vec_ff;
      a_in         = a_ff;
      neg_in       = neg_ff;
      ax_in        = ax_ff;
      grp_in       = grp_ff;
      acc_in       = acc_ff;
      prod_in      = op_a * op_b;
      umag_in      = umag_ff;
      dist_in      = dist_ff;
      mag_in       = mag_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_if.ready) out_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               item_in = q_head.item;
               ax_in   = '0;
               acc_in  = '0;
               if (!q_head.item.is_neighbor) begin
                  for (int i = 0; i < AXES; i++) begin
                     agent_pos_in[i] = $signed(q_head.item.pos[i]);
                     agent_vel_in[i] = $signed(q_head.item.vel[i]);
                     sep_sum_in[i]   = '0;
                     vel_sum_in[i]   = '0;
                     pos_sum_in[i]   = '0;
                  end
                  sep_cnt_in = '0;
                  ali_cnt_in = '0;
                  coh_cnt_in = '0;
               end else begin
                  d_in = diff;
               end
            end
         end
         ST_SQ_ACC, ST_M_ACC: begin
            acc_in = acc_ff + prod_ff;
            ax_in  = ax_ff + 1'b1;
         end
         ST_DIST_WAIT: if (sqrt_rsp.done) dist_in = sqrt_rsp.root;
         ST_CLASSIFY: begin
            ax_in = '0;
            if (dist_ff != '0) begin
               if (ali_ok) begin
                  for (int i = 0; i < AXES; i++) begin
                     vel_sum_in[i] = vel_sum_ff[i] + SUM_W'($signed(item_ff.vel[i]));
                  end
                  ali_cnt_in = ali_cnt_ff + 1'b1;
               end
               if (coh_ok) begin
                  for (int i = 0; i < AXES; i++) begin
                     pos_sum_in[i] = pos_sum_ff[i] + SUM_W'($signed(item_ff.pos[i]));
                  end
                  coh_cnt_in = coh_cnt_ff + 1'b1;
               end
            end
         end
         ST_U_WAIT: if (div_rsp.done) umag_in = div_rsp.quo;
         ST_T_WAIT: begin
            if (div_rsp.done) begin
               sep_sum_in[ax_ff] = sep_sum_ff[ax_ff] + SUM_W'($signed(
                  sat_val(d_ff[ax_ff][DIFF_W-1] ? -q_wide : q_wide)));
               ax_in = ax_ff + 1'b1;
               if (ax_ff == 2'd2) sep_cnt_in = sep_cnt_ff + 1'b1;
            end
         end
         ST_CHECK_LAST: begin
            grp_in = GRP_SEP;
            ax_in  = '0;
            if (item_ff.last) res_in = '0;
         end
         ST_GROUP: begin
            ax_in = '0;
            if (grp_cnt == '0) begin
               grp_in = grp_ff + 1'b1;
            end else if (grp_ff == GRP_SEP) begin
               vec_in = sep_sum_ff;
            end else if (grp_ff == GRP_ALI) begin
               vec_in = vel_sum_ff;
            end
         end
         ST_C_WAIT: begin
            if (div_rsp.done) begin
               vec_in[ax_ff] = SUM_W'((pos_sum_ff[ax_ff][SUM_W-1] ? -q_wide : q_wide)
                                      - WIDE_W'(agent_pos_ff[ax_ff]));
               ax_in = ax_ff + 1'b1;
            end
         end
         ST_ABS: begin
            for (int i = 0; i < AXES; i++) begin
               neg_in[i] = vec_ff[i][SUM_W-1];
               a_in[i]   = vec_ff[i][SUM_W-1] ? SUM_W'(-vec_ff[i]) : SUM_W'(vec_ff[i]);
            end
         end
         ST_NORM: begin
            if (m_val == '0) begin
               for (int k = 0; k < AXES; k++) begin
                  res_in[4'(grp_ff) * 4'd3 + 4'(k)] = sat_val(-WIDE_W'(agent_vel_ff[k]));
               end
               grp_in = grp_ff + 1'b1;
            end else if (m_val >= NORM_HI) begin
               for (int i = 0; i < AXES; i++) a_in[i] = a_ff[i] >> 1;
            end else if (m_val < NORM_LO) begin
               for (int i = 0; i < AXES; i++) a_in[i] = a_ff[i] << 1;
            end else begin
               ax_in  = '0;
               acc_in = '0;
            end
         end
         ST_MAG_WAIT: begin
            ax_in = '0;
            if (sqrt_rsp.done) mag_in = sqrt_rsp.root;
         end
         ST_S_WAIT: begin
            if (div_rsp.done) begin
               res_in[res_idx] = sat_val((neg_ff[ax_ff] ? -q_wide : q_wide)
                                         - WIDE_W'(agent_vel_ff[ax_ff]));
               ax_in = ax_ff + 1'b1;
               if (ax_ff == 2'd2) grp_in = grp_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (emit_load) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      d_ff    <= d_in;
      vec_ff  <= vec_in;
      a_ff    <= a_in;
      neg_ff  <= neg_in;
      ax_ff   <= ax_in;
      grp_ff  <= grp_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      umag_ff <= umag_in;
      dist_ff <= dist_in;
      mag_ff  <= mag_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         sep_cnt_ff   <= '0;
         ali_cnt_ff   <= '0;
         coh_cnt_ff   <= '0;
         for (int i = 0; i < AXES; i++) begin
            agent_pos_ff[i] <= '0;
            agent_vel_ff[i] <= '0;
            sep_sum_ff[i]   <= '0;
            vel_sum_ff[i]   <= '0;
            pos_sum_ff[i]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         sep_cnt_ff   <= sep_cnt_in;
         ali_cnt_ff   <= ali_cnt_in;
         coh_cnt_ff   <= coh_cnt_in;
         agent_pos_ff <= agent_pos_in;
         agent_vel_ff <= agent_vel_in;
         sep_sum_ff   <= sep_sum_in;
         vel_sum_ff   <= vel_sum_in;
         pos_sum_ff   <= pos_sum_in;
      end
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.sep_x   = out_ff[0];
   assign rsp_if.sep_y   = out_ff[1];
   assign rsp_if.sep_z   = out_ff[2];
   assign rsp_if.align_x = out_ff[3];
   assign rsp_if.align_y = out_ff[4];
   assign rsp_if.align_z = out_ff[5];
   assign rsp_if.coh_x   = out_ff[6];
   assign rsp_if.coh_y   = out_ff[7];
   assign rsp_if.coh_z   = out_ff[8];

endmodule
`default_nettype wire

### sv/flocking_force_accumulator.sv
// Back end: an agent item goes through IDLE and CHECK_LAST; a neighbor waits on the 32-step root unit;
// a separating neighbor adds six passes of the 64-step divider.
// Item marked last adds steering per force (normalize shifts, root, three divides),
// plus three count divides for cohesion. One item in the back end at a time.
// A two-entry queue takes requests while the back end works; a new result loads as the last is taken.
// Synchronous active-high reset clears the queue, sums, counts and agent state; config gets defaults.
`timescale 1ns / 1ps
`default_nettype none
module flocking_force_accumulator import ffa_pkg::*; (
   input  wire                  clock,
   input  wire                  reset,
   ffa_req_if.sink              req_if,
   ffa_rsp_if.source            rsp_if,
   input  wire                  csr_we,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [RAD_W-1:0]      csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   q_head_type   q_head;
   logic         pop;
   div_req_type  div_req;
   div_rsp_type  div_rsp;
   sqrt_req_type sqrt_req;
   sqrt_rsp_type sqrt_rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_SEP_RAD:   cfg_in.sep_rad   = csr_wdata;
            CSR_ALI_RAD:   cfg_in.ali_rad   = csr_wdata;
            CSR_COH_RAD:   cfg_in.coh_rad   = csr_wdata;
            CSR_MAX_SPEED: cfg_in.max_speed = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sep_rad   <= SEP_RAD_RESET;
         cfg_ff.ali_rad   <= ALI_RAD_RESET;
         cfg_ff.coh_rad   <= COH_RAD_RESET;
         cfg_ff.max_speed <= MAX_SPEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ffa_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .q_head (q_head),
      .pop    (pop)
   );

   ffa_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   ffa_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .sqrt_req (sqrt_req),
      .sqrt_rsp (sqrt_rsp)
   );

   ffa_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_head   (q_head),
      .pop      (pop),
      .div_req  (div_req),
      .div_rsp  (div_rsp),
      .sqrt_req (sqrt_req),
      .sqrt_rsp (sqrt_rsp),
      .rsp_if   (rsp_if)
   );

`ifndef SYNTHESIS
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_head.valid)
      else $error("pop from empty queue");

   a_max_speed_write: assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_index == CSR_MAX_SPEED) |=> (cfg_ff.max_speed == $past(csr_wdata)))
      else $error("max_speed write lost");

   a_div_not_restarted: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> !div_req.start)
      else $error("divider restarted back to back");
`endif

endmodule
`default_nettype wire
